FILE: sv/ntc_pkg.sv
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int FRAC_BITS_DEF = 24;

  localparam int SAMPLE_W   = 16;
  localparam int TEMP_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int REF_W   = 16;
  localparam int BETA_W  = 15;
  localparam int OHMS_W  = 20;
  localparam int NOMC_W  = 15;

  localparam int LOG_N_W = 20;
  localparam int K_W     = 5;
  localparam int MANT_W  = 31;
  localparam int QUOT_W  = 18;

  localparam int KELVIN_OFFSET = 27315;
  localparam int TOP_LIMIT     = 100000;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [REF_W-1:0]  REF_RST  = 16'd5000;
  localparam logic [BETA_W-1:0] BETA_RST = 15'd3988;
  localparam logic [OHMS_W-1:0] FIX_RST  = 20'd10000;
  localparam logic [OHMS_W-1:0] NOM_RST  = 20'd10000;
  localparam logic [NOMC_W-1:0] NOMC_RST = 15'd2500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFERENCE_MV    = 3'd0,
    CFG_BETA_KELVIN     = 3'd1,
    CFG_FIXED_OHMS      = 3'd2,
    CFG_NOMINAL_OHMS    = 3'd3,
    CFG_NOMINAL_CENTI_C = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic bad;
  } tag_t;

endpackage

FILE: sv/ntc_log2_pipe.sv
`timescale 1ns / 1ps

module ntc_log2_pipe #(
  parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [ntc_pkg::LOG_N_W-1:0]            n,
  output logic [FRAC_BITS+ntc_pkg::K_W-1:0]      log_q
);

  localparam int MW  = ntc_pkg::MANT_W;
  localparam int MFR = MW - 1;

  logic [MW-1:0]               mant_r [0:FRAC_BITS];
  logic [ntc_pkg::K_W-1:0]     k_r    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]        frac_r [0:FRAC_BITS];

  logic [ntc_pkg::K_W-1:0]     k_nxt;
  logic [MW-1:0]               mant_nxt;

  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < ntc_pkg::LOG_N_W; i++) begin
      if (n[i]) begin
        k_nxt = ntc_pkg::K_W'(i);
      end
    end
    mant_nxt = MW'({n, {MFR{1'b0}}} >> k_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_r[0] <= mant_nxt;
      k_r[0]    <= k_nxt;
      frac_r[0] <= '0;
    end
  end

  for (genvar s = 1; s <= FRAC_BITS; s++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     sh;
    logic            bit_c;
    logic [MW-1:0]   m_nxt;

    assign sq    = {{MW{1'b0}}, mant_r[s-1]} * {{MW{1'b0}}, mant_r[s-1]};
    assign sh    = sq[2*MW-1:MFR];
    assign bit_c = sh[MW];
    assign m_nxt = bit_c ? sh[MW:1] : sh[MW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        mant_r[s] <= m_nxt;
        k_r[s]    <= k_r[s-1];
        frac_r[s] <= {frac_r[s-1][FRAC_BITS-2:0], bit_c};
      end
    end
  end

  assign log_q = {k_r[FRAC_BITS], frac_r[FRAC_BITS]};

endmodule

FILE: sv/ntc_div_pipe.sv
`timescale 1ns / 1ps

module ntc_div_pipe #(
  parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  ntc_pkg::tag_t                tag_i,
  input  logic [FRAC_BITS+23:0]        d_i,
  input  logic [FRAC_BITS+37:0]        n_i,
  output ntc_pkg::tag_t                tag_o,
  output logic [ntc_pkg::QUOT_W-1:0]   q_o,
  output logic                         sat_o
);

  localparam int DW = FRAC_BITS + 24;
  localparam int NW = FRAC_BITS + 38;
  localparam int CW = FRAC_BITS + 43;
  localparam int QB = ntc_pkg::QUOT_W;
  localparam int NS = QB + 1;

  ntc_pkg::tag_t   tag_r [0:NS-1];
  logic [NW-1:0]   rem_r [0:NS-1];
  logic [DW-1:0]   d_r   [0:NS-1];
  logic [QB-1:0]   q_r   [0:NS-1];
  logic            sat_r [0:NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int P = QB - j;

    ntc_pkg::tag_t tag_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] q_in;
    logic          sat_in;
    logic [CW-1:0] dsh;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QB-1:0] q_nxt;
    logic          sat_nxt;

    if (j == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = n_i;
      assign d_in   = d_i;
      assign q_in   = '0;
      assign sat_in = 1'b0;
    end else begin : g_next
      assign tag_in = tag_r[j-1];
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign dsh = CW'(d_in) << P;
    assign ge  = CW'(rem_in) >= dsh;

    if (j == 0) begin : g_ovf
      assign sat_nxt = ge;
      assign rem_nxt = rem_in;
      assign q_nxt   = q_in;
    end else begin : g_bit
      always_comb begin
        sat_nxt  = sat_in;
        rem_nxt  = ge ? NW'(CW'(rem_in) - dsh) : rem_in;
        q_nxt    = q_in;
        q_nxt[P] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j] <= '0;
      end else if (en) begin
        tag_r[j] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        d_r[j]   <= d_in;
        q_r[j]   <= q_nxt;
        sat_r[j] <= sat_nxt;
      end
    end
  end

  assign tag_o = tag_r[NS-1];
  assign q_o   = q_r[NS-1];
  assign sat_o = sat_r[NS-1];

endmodule

FILE: sv/ntc_voltage_to_temperature_unit.sv
`timescale 1ns / 1ps

// NTC divider voltage to temperature. Each transfer on the in_ channel carries one sample in
// millivolts; one result follows on the out_ channel in hundredths of a degree Celsius with an
// invalid flag (sample at zero or at/above the reference, a zero beta or resistor setting, or a
// non-positive Beta denominator give -27315 and invalid). Results above 100000 clip to 100000.
// A new sample is taken every cycle unless out_stall holds a result while another waits behind it.
// Samples pass FRAC_BITS mantissa squarings in four log2 units and 19 restoring divider steps.
// Write the cfg_ registers only while no sample is in flight.

module ntc_voltage_to_temperature_unit #(
  parameter int FRAC_BITS = ntc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ntc_pkg::SAMPLE_W-1:0]         in_sample_mv,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0]    out_temp_centi_c,
  output logic                                 out_invalid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int LW   = FRAC_BITS + ntc_pkg::K_W;
  localparam int YW   = FRAC_BITS + 7;
  localparam int YAW  = FRAC_BITS + 6;
  localparam int TZW  = YAW + 18;
  localparam int DENW = FRAC_BITS + 25;
  localparam int DW   = FRAC_BITS + 24;
  localparam int NW   = FRAC_BITS + 38;
  localparam int QB   = ntc_pkg::QUOT_W;
  localparam int TW   = ntc_pkg::TEMP_W;

  logic [ntc_pkg::REF_W-1:0]         ref_r;
  logic [ntc_pkg::BETA_W-1:0]        beta_r;
  logic [ntc_pkg::OHMS_W-1:0]        fix_r;
  logic [ntc_pkg::OHMS_W-1:0]        nom_r;
  logic [ntc_pkg::NOMC_W-1:0]        nomc_r;

  logic [15:0]                       t0_r;
  logic [30:0]                       tb_r;
  logic [37:0]                       num_r;
  logic [21:0]                       bterm_r;
  logic signed [16:0]                t0_nxt;

  logic                              en_out;
  logic                              en_pipe;

  ntc_pkg::tag_t                     tag_l_r [0:FRAC_BITS];
  ntc_pkg::tag_t                     tag_in_nxt;
  logic [ntc_pkg::SAMPLE_W-1:0]      diff_nxt;
  logic [LW-1:0]                     l_smp, l_fix, l_dif, l_nom;

  ntc_pkg::tag_t                     tag_y_r, tag_m1_r, tag_m2_r, tag_t_r, tag_d_r;
  logic signed [YW-1:0]              y_nxt;
  logic [YAW-1:0]                    ya_r;
  logic                              yneg_r, yneg_m1_r;
  logic [63:0]                       ya64;
  logic [63:0]                       ph_nxt, pl_nxt;
  logic [YAW-1:0]                    phi_r;
  logic [31:0]                       plo_r;
  logic [YAW-1:0]                    zabs_nxt;
  logic signed [YAW:0]               z_r;
  logic signed [TZW-1:0]             tz_r;
  logic signed [DENW-1:0]            den_nxt;
  logic                              den_pos;
  logic [DW-1:0]                     d_r;

  ntc_pkg::tag_t                     tag_q;
  logic [QB-1:0]                     q_q;
  logic                              sat_q;

  logic                              out_valid_r;
  logic signed [TW-1:0]              out_temp_r;
  logic                              out_invalid_r;
  logic signed [TW-1:0]              temp_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= ntc_pkg::REF_RST;
      beta_r <= ntc_pkg::BETA_RST;
      fix_r  <= ntc_pkg::FIX_RST;
      nom_r  <= ntc_pkg::NOM_RST;
      nomc_r <= ntc_pkg::NOMC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ntc_pkg::cfg_idx_t'(cfg_index))
        ntc_pkg::CFG_REFERENCE_MV:    ref_r  <= cfg_data[ntc_pkg::REF_W-1:0];
        ntc_pkg::CFG_BETA_KELVIN:     beta_r <= cfg_data[ntc_pkg::BETA_W-1:0];
        ntc_pkg::CFG_FIXED_OHMS:      fix_r  <= cfg_data[ntc_pkg::OHMS_W-1:0];
        ntc_pkg::CFG_NOMINAL_OHMS:    nom_r  <= cfg_data[ntc_pkg::OHMS_W-1:0];
        ntc_pkg::CFG_NOMINAL_CENTI_C: nomc_r <= cfg_data[ntc_pkg::NOMC_W-1:0];
        default: ;
      endcase
    end
  end

  // derived constants, settled long before any sample needs them
  assign t0_nxt = 17'(signed'(nomc_r)) + 17'sd27315;

  always_ff @(posedge clk) begin
    t0_r    <= t0_nxt[15:0];
    tb_r    <= 31'({15'd0, t0_r} * {16'd0, beta_r});
    num_r   <= 38'({7'd0, tb_r} * 38'd100);
    bterm_r <= 22'({7'd0, beta_r} * 22'd100);
  end

  assign en_out   = !out_valid_r || !out_stall;
  assign en_pipe  = en_out || !tag_q.vld;
  assign in_stall = !en_pipe;

  assign diff_nxt = ref_r - in_sample_mv;

  always_comb begin
    tag_in_nxt.vld = in_valid;
    tag_in_nxt.bad = (in_sample_mv == '0) || (in_sample_mv >= ref_r) || (beta_r == '0) ||
                     (fix_r == '0) || (nom_r == '0);
  end

  ntc_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_smp (
    .clk(clk), .en(en_pipe), .n(ntc_pkg::LOG_N_W'(in_sample_mv)), .log_q(l_smp)
  );
  ntc_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_fix (
    .clk(clk), .en(en_pipe), .n(fix_r), .log_q(l_fix)
  );
  ntc_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_dif (
    .clk(clk), .en(en_pipe), .n(ntc_pkg::LOG_N_W'(diff_nxt)), .log_q(l_dif)
  );
  ntc_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_nom (
    .clk(clk), .en(en_pipe), .n(nom_r), .log_q(l_nom)
  );

  for (genvar s = 0; s <= FRAC_BITS; s++) begin : g_tag
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_l_r[s] <= '0;
      end else if (en_pipe) begin
        tag_l_r[s] <= (s == 0) ? tag_in_nxt : tag_l_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign y_nxt = signed'(YW'(l_smp)) + signed'(YW'(l_fix))
               - signed'(YW'(l_dif)) - signed'(YW'(l_nom));

  assign ya64     = 64'(ya_r);
  assign ph_nxt   = {32'd0, ya64[63:32]} * {32'd0, ntc_pkg::LN2_Q32};
  assign pl_nxt   = {32'd0, ya64[31:0]} * {32'd0, ntc_pkg::LN2_Q32};
  assign zabs_nxt = phi_r + YAW'(plo_r);

  assign den_nxt = signed'(DENW'({bterm_r, {FRAC_BITS{1'b0}}})) + DENW'(tz_r);
  assign den_pos = !den_nxt[DENW-1] && (den_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_y_r  <= '0;
      tag_m1_r <= '0;
      tag_m2_r <= '0;
      tag_t_r  <= '0;
      tag_d_r  <= '0;
    end else if (en_pipe) begin
      tag_y_r     <= tag_l_r[FRAC_BITS];
      tag_m1_r    <= tag_y_r;
      tag_m2_r    <= tag_m1_r;
      tag_t_r     <= tag_m2_r;
      tag_d_r.vld <= tag_t_r.vld;
      tag_d_r.bad <= tag_t_r.bad || !den_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      yneg_r    <= y_nxt[YW-1];
      ya_r      <= y_nxt[YW-1] ? YAW'(-y_nxt) : YAW'(y_nxt);
      yneg_m1_r <= yneg_r;
      phi_r     <= YAW'(ph_nxt);
      plo_r     <= pl_nxt[63:32];
      z_r       <= yneg_m1_r ? -signed'({1'b0, zabs_nxt}) : signed'({1'b0, zabs_nxt});
      tz_r      <= TZW'(signed'({1'b0, t0_r})) * TZW'(z_r);
      d_r       <= DW'(den_nxt);
    end
  end

  ntc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en_pipe),
    .tag_i (tag_d_r),
    .d_i   (d_r),
    .n_i   (NW'({num_r, {FRAC_BITS{1'b0}}})),
    .tag_o (tag_q),
    .q_o   (q_q),
    .sat_o (sat_q)
  );

  always_comb begin
    if (tag_q.bad) begin
      temp_nxt = TW'(-ntc_pkg::KELVIN_OFFSET);
    end else if (sat_q || (q_q > QB'(ntc_pkg::TOP_LIMIT + ntc_pkg::KELVIN_OFFSET))) begin
      temp_nxt = TW'(ntc_pkg::TOP_LIMIT);
    end else begin
      temp_nxt = signed'(TW'(q_q) - TW'(ntc_pkg::KELVIN_OFFSET));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= tag_q.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && tag_q.vld) begin
      out_temp_r    <= temp_nxt;
      out_invalid_r <= tag_q.bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi_c = out_temp_r;
  assign out_invalid      = out_invalid_r;

  a_invalid_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_temp_centi_c == TW'(-ntc_pkg::KELVIN_OFFSET))
    else $error("invalid result without absolute zero temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |->
      out_temp_centi_c >= TW'(-ntc_pkg::KELVIN_OFFSET) &&
      out_temp_centi_c <= TW'(ntc_pkg::TOP_LIMIT))
    else $error("valid temperature out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && tag_q.vld)
    else $error("input held without a full pipeline");

endmodule

FILE: tb/sv/ntc_voltage_to_temperature_unit_tb.sv
`timescale 1ns / 1ps

module ntc_voltage_to_temperature_unit_tb;

  localparam int FB = ntc_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = FB + 26;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SW = ntc_pkg::SAMPLE_W;
  localparam int TMW = ntc_pkg::TEMP_W;
  localparam int CDW = ntc_pkg::CFG_DATA_W;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [SW-1:0] in_sample_mv;
  logic out_valid;
  logic out_stall;
  logic signed [TMW-1:0] out_temp_centi_c;
  logic out_invalid;
  logic cfg_valid;
  logic cfg_ready;
  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;

  ntc_voltage_to_temperature_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_mv(in_sample_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temp_centi_c(out_temp_centi_c), .out_invalid(out_invalid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [TMW-1:0] temp;
    logic bad;
  } reading_t;

  logic [ntc_pkg::REF_W-1:0] m_ref;
  logic [ntc_pkg::BETA_W-1:0] m_beta;
  logic [ntc_pkg::OHMS_W-1:0] m_fixed;
  logic [ntc_pkg::OHMS_W-1:0] m_nom;
  logic signed [ntc_pkg::NOMC_W-1:0] m_nomc;

  logic [SW-1:0] pending_samples[$];
  reading_t expected_readings[$];

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_invalid = 0;
  int n_clipped = 0;
  int n_cfg = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit no_idle = 0;
  bit in_fired = 0;

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned n);
    int k;
    longint unsigned m;
    longint unsigned frac;
    k = 0;
    frac = 0;
    while (k < 63 && (n >> (k + 1)) != 0) k++;
    m = (n << 30) >> k;
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << FB) | frac;
  endfunction

  function automatic longint unsigned scale_ln2(longint unsigned a);
    longint unsigned hi;
    longint unsigned lo;
    hi = a >> 32;
    lo = a & 64'hFFFF_FFFF;
    return hi * longint'(ntc_pkg::LN2_Q32) + ((lo * longint'(ntc_pkg::LN2_Q32)) >> 32);
  endfunction

  function automatic reading_t convert_sample(logic [SW-1:0] s);
    reading_t r;
    longint t0, y, z, den, tc;
    longint unsigned d, num, q, rem;
    bit sat;
    tc = -ntc_pkg::KELVIN_OFFSET;
    r.bad = 1;
    if (s != 0 && s < m_ref && m_beta != 0 && m_fixed != 0 && m_nom != 0) begin
      t0 = longint'(m_nomc) + ntc_pkg::KELVIN_OFFSET;
      y = longint'(log2_fix(s)) + longint'(log2_fix(m_fixed))
        - longint'(log2_fix(m_ref - s)) - longint'(log2_fix(m_nom));
      z = (y < 0) ? -longint'(scale_ln2(-y)) : longint'(scale_ln2(y));
      den = (longint'(100 * longint'(m_beta)) << FB) + t0 * z;
      if (den > 0) begin
        d = den;
        num = 100 * t0 * longint'(m_beta);
        q = num / d;
        rem = num % d;
        sat = 0;
        for (int i = 0; i < FB; i++) begin
          if (q > (64'd1 << 40)) begin
            sat = 1;
            break;
          end
          q = q << 1;
          rem = rem << 1;
          if (rem >= d) begin
            rem = rem - d;
            q = q | 1;
          end
        end
        if (sat || q > longint'(ntc_pkg::TOP_LIMIT + ntc_pkg::KELVIN_OFFSET))
          tc = ntc_pkg::TOP_LIMIT;
        else tc = longint'(q) - ntc_pkg::KELVIN_OFFSET;
        r.bad = 0;
      end
    end
    r.temp = tc[TMW-1:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fired) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1;
          in_sample_mv <= pending_samples.pop_front();
          in_gap <= pick_gap();
        end else begin
          in_valid <= 0;
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(0, 9) < 3) out_gap <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t e;
    in_fired <= in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        expected_readings.push_back(convert_sample(in_sample_mv));
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result temp=%0d invalid=%0b",
                   $time, out_temp_centi_c, out_invalid);
          errors++;
        end else begin
          e = expected_readings.pop_front();
          if (e.bad) n_invalid++;
          if (!e.bad && e.temp == ntc_pkg::TOP_LIMIT) n_clipped++;
          if (out_temp_centi_c !== e.temp) begin
            $display("%0t: temp mismatch expected %0d actual %0d",
                     $time, e.temp, out_temp_centi_c);
            errors++;
          end
          if (out_invalid !== e.bad) begin
            $display("%0t: invalid mismatch expected %0b actual %0b",
                     $time, e.bad, out_invalid);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(ntc_pkg::cfg_idx_t idx, logic [CDW-1:0] value);
    write_raw(idx, value);
  endtask

  task automatic write_raw(logic [ntc_pkg::CFG_IDX_W-1:0] idx, logic [CDW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ntc_pkg::CFG_REFERENCE_MV: m_ref = value[ntc_pkg::REF_W-1:0];
      ntc_pkg::CFG_BETA_KELVIN: m_beta = value[ntc_pkg::BETA_W-1:0];
      ntc_pkg::CFG_FIXED_OHMS: m_fixed = value[ntc_pkg::OHMS_W-1:0];
      ntc_pkg::CFG_NOMINAL_OHMS: m_nom = value[ntc_pkg::OHMS_W-1:0];
      ntc_pkg::CFG_NOMINAL_CENTI_C: m_nomc = value[ntc_pkg::NOMC_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic setup(int r, int b, int f, int n, int c);
    write_reg(ntc_pkg::CFG_REFERENCE_MV, r[CDW-1:0]);
    write_reg(ntc_pkg::CFG_BETA_KELVIN, b[CDW-1:0]);
    write_reg(ntc_pkg::CFG_FIXED_OHMS, f[CDW-1:0]);
    write_reg(ntc_pkg::CFG_NOMINAL_OHMS, n[CDW-1:0]);
    write_reg(ntc_pkg::CFG_NOMINAL_CENTI_C, c[CDW-1:0]);
  endtask

  task automatic run_batch(int count);
    int s;
    pending_samples.push_back(SW'(0));
    pending_samples.push_back(SW'(1));
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(m_ref / 2);
    if (m_ref > 1) pending_samples.push_back(m_ref - 1);
    pending_samples.push_back(m_ref);
    if (m_ref < 16'hFFFF) pending_samples.push_back(m_ref + 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8 && m_ref > 1) s = $urandom_range(1, m_ref - 1);
      else s = $urandom_range(0, 16'hFFFF);
      pending_samples.push_back(SW'(s));
    end
    do begin
      @(negedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_sample_mv = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    m_ref = ntc_pkg::REF_RST;
    m_beta = ntc_pkg::BETA_RST;
    m_fixed = ntc_pkg::FIX_RST;
    m_nom = ntc_pkg::NOM_RST;
    m_nomc = ntc_pkg::NOMC_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    run_batch(100);
    setup(65535, 20000, 1000000, 1, -5500);
    run_batch(100);
    setup(65535, 1, 1, 1000000, 15000);
    run_batch(100);
    no_idle = 1;
    setup(1, 3988, 10000, 10000, 2500);
    run_batch(20);
    setup(3300, 32767, 1048575, 1048575, -16384);
    run_batch(100);
    no_idle = 0;
    setup(5000, 0, 10000, 10000, 2500);
    run_batch(20);
    setup(5000, 3988, 0, 10000, 2500);
    run_batch(20);
    setup(5000, 3988, 10000, 0, 16383);
    run_batch(20);
    write_raw(5, 20'hFFFFF);
    write_raw(6, 20'h12345);
    write_raw(7, 20'hAAAAA);
    run_batch(20);
    for (int p = 0; p < 7; p++) begin
      no_idle = (p == 3);
      setup($urandom_range(1, 65535), $urandom_range(1, 20000), $urandom_range(1, 1000000),
            $urandom_range(1, 1000000), $urandom_range(0, 20500) - 5500);
      run_batch(80);
    end

    $display("samples %0d results %0d invalid %0d clipped %0d register writes %0d",
             n_in, n_out, n_invalid, n_clipped, n_cfg);
    $display("covered reset, extreme, zero and random register settings");
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
